>>> hdl/spo_pkg.sv
// shared types and constants for the shape pair overlap test
// no dependencies; used by every module of the block
package spo_pkg;

   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = 14;
   localparam int WIDE_BITS  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
   localparam int EDGE_BITS  = WIDE_BITS + 2;
   localparam int RAD_BITS   = SIZE_BITS + 1;
   localparam int SQ_BITS    = 2 * EDGE_BITS;
   localparam int RSQ_BITS   = 2 * RAD_BITS;
   localparam int SUM_BITS   = ((SQ_BITS > RSQ_BITS) ? SQ_BITS : RSQ_BITS) + 1;

   typedef enum logic [1:0] {
      KIND_CC,
      KIND_RR,
      KIND_CR
   } kind_type;

   typedef struct packed {
      logic                  is_rect;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [SIZE_BITS-1:0]  a;
      logic [SIZE_BITS-1:0]  b;
   } shape_type;

   typedef struct packed {
      logic                 is_rect;
      logic [SIZE_BITS-1:0] rad;
      logic [EDGE_BITS-1:0] cx;
      logic [EDGE_BITS-1:0] cy;
      logic [EDGE_BITS-1:0] l;
      logic [EDGE_BITS-1:0] r;
      logic [EDGE_BITS-1:0] t;
      logic [EDGE_BITS-1:0] b;
   } geo_type;

   typedef struct packed {
      logic valid;
      logic use_rr;
      logic rr_hit;
   } ctl_type;

endpackage

>>> hdl/spo_box.sv
// edge and centre computation for one shape
// depends on spo_pkg
module spo_box (
   input  spo_pkg::shape_type shape,
   output spo_pkg::geo_type   geo
);

   logic signed [spo_pkg::EDGE_BITS-1:0] cx;
   logic signed [spo_pkg::EDGE_BITS-1:0] cy;
   logic signed [spo_pkg::EDGE_BITS-1:0] half_w;
   logic signed [spo_pkg::EDGE_BITS-1:0] half_h;
   logic signed [spo_pkg::EDGE_BITS-1:0] full_w;
   logic signed [spo_pkg::EDGE_BITS-1:0] full_h;
   logic signed [spo_pkg::EDGE_BITS-1:0] left;
   logic signed [spo_pkg::EDGE_BITS-1:0] top;

   assign cx = $signed({{(spo_pkg::EDGE_BITS-spo_pkg::COORD_BITS){shape.x[spo_pkg::COORD_BITS-1]}},
                        shape.x});
   assign cy = $signed({{(spo_pkg::EDGE_BITS-spo_pkg::COORD_BITS){shape.y[spo_pkg::COORD_BITS-1]}},
                        shape.y});

   assign half_w = $signed({{(spo_pkg::EDGE_BITS-spo_pkg::SIZE_BITS+1){1'b0}},
                            shape.a[spo_pkg::SIZE_BITS-1:1]});
   assign half_h = $signed({{(spo_pkg::EDGE_BITS-spo_pkg::SIZE_BITS+1){1'b0}},
                            shape.b[spo_pkg::SIZE_BITS-1:1]});
   assign full_w = $signed({{(spo_pkg::EDGE_BITS-spo_pkg::SIZE_BITS){1'b0}}, shape.a});
   assign full_h = $signed({{(spo_pkg::EDGE_BITS-spo_pkg::SIZE_BITS){1'b0}}, shape.b});

   assign left = cx - half_w;
   assign top  = cy - half_h;

   assign geo.is_rect = shape.is_rect;
   assign geo.rad     = shape.a;
   assign geo.cx      = cx;
   assign geo.cy      = cy;
   assign geo.l       = left;
   assign geo.r       = left + full_w;
   assign geo.t       = top;
   assign geo.b       = top + full_h;

endmodule

>>> hdl/spo_dist.sv
// squaring stage and distance compare, drives the result register
// depends on spo_pkg
module spo_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  spo_pkg::ctl_type              ctl,
   input  logic [spo_pkg::EDGE_BITS-1:0] dx,
   input  logic [spo_pkg::EDGE_BITS-1:0] dy,
   input  logic [spo_pkg::RAD_BITS-1:0]  rs,
   output logic                          strobe,
   output logic                          overlap
);

   spo_pkg::ctl_type                   ctl_ff;
   logic signed [spo_pkg::SQ_BITS-1:0] dx_sq_s;
   logic signed [spo_pkg::SQ_BITS-1:0] dy_sq_s;
   logic [spo_pkg::SQ_BITS-1:0]        dx_sq_in;
   logic [spo_pkg::SQ_BITS-1:0]        dy_sq_in;
   logic [spo_pkg::RSQ_BITS-1:0]       rs_sq_in;
   logic [spo_pkg::SQ_BITS-1:0]        dx_sq_ff;
   logic [spo_pkg::SQ_BITS-1:0]        dy_sq_ff;
   logic [spo_pkg::RSQ_BITS-1:0]       rs_sq_ff;
   logic [spo_pkg::SUM_BITS-1:0]       dist_sq;
   logic                               overlap_in;
   logic                               strobe_ff;
   logic                               overlap_ff;

   assign dx_sq_s  = $signed(dx) * $signed(dx);
   assign dy_sq_s  = $signed(dy) * $signed(dy);
   assign dx_sq_in = $unsigned(dx_sq_s);
   assign dy_sq_in = $unsigned(dy_sq_s);
   assign rs_sq_in = spo_pkg::RSQ_BITS'(rs) * spo_pkg::RSQ_BITS'(rs);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      dx_sq_ff <= dx_sq_in;
      dy_sq_ff <= dy_sq_in;
      rs_sq_ff <= rs_sq_in;
   end

   assign dist_sq    = spo_pkg::SUM_BITS'(dx_sq_ff) + spo_pkg::SUM_BITS'(dy_sq_ff);
   assign overlap_in = ctl_ff.use_rr ? ctl_ff.rr_hit
                                     : (dist_sq < spo_pkg::SUM_BITS'(rs_sq_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      overlap_ff <= overlap_in;
   end

   assign strobe  = strobe_ff;
   assign overlap = overlap_ff;

endmodule

>>> hdl/shape_pair_overlap_test.sv
// top level of the shape pair overlap test: input register, edge and delta stages
// depends on spo_pkg, spo_box and spo_dist
//
//   channel   ports                        transfer when
//   request   start, busy, req_*           start high and busy low
//   response  rsp_strobe, rsp_overlap      rsp_strobe high, one cycle
//
// one shape pair accepted every cycle, sustained
// each result passes through the five register stages after its transfer
//   (input, edges, deltas, squares, compare)
// synchronous reset clears all valid bits; busy is high in reset and for the first cycle after it
// results cannot be held off, so nothing ever stalls
module shape_pair_overlap_test (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_first_is_rect,
   input  logic [spo_pkg::COORD_BITS-1:0] req_first_x,
   input  logic [spo_pkg::COORD_BITS-1:0] req_first_y,
   input  logic [spo_pkg::SIZE_BITS-1:0]  req_first_size_a,
   input  logic [spo_pkg::SIZE_BITS-1:0]  req_first_size_b,
   input  logic                           req_second_is_rect,
   input  logic [spo_pkg::COORD_BITS-1:0] req_second_x,
   input  logic [spo_pkg::COORD_BITS-1:0] req_second_y,
   input  logic [spo_pkg::SIZE_BITS-1:0]  req_second_size_a,
   input  logic [spo_pkg::SIZE_BITS-1:0]  req_second_size_b,
   output logic                           rsp_strobe,
   output logic                           rsp_overlap
);

   logic                          busy_ff;
   logic                          in_valid_ff;
   spo_pkg::shape_type            p_shape_ff;
   spo_pkg::shape_type            q_shape_ff;
   spo_pkg::geo_type              p_geo_in;
   spo_pkg::geo_type              q_geo_in;
   logic                          geo_valid_ff;
   spo_pkg::geo_type              p_geo_ff;
   spo_pkg::geo_type              q_geo_ff;
   spo_pkg::kind_type             kind;
   spo_pkg::geo_type              circ;
   spo_pkg::geo_type              rect;
   logic [spo_pkg::EDGE_BITS-1:0] dx_in;
   logic [spo_pkg::EDGE_BITS-1:0] dy_in;
   logic [spo_pkg::RAD_BITS-1:0]  rs_in;
   logic                          rr_hit_in;
   spo_pkg::ctl_type              ctl_in;
   spo_pkg::ctl_type              ctl_ff;
   logic [spo_pkg::EDGE_BITS-1:0] dx_ff;
   logic [spo_pkg::EDGE_BITS-1:0] dy_ff;
   logic [spo_pkg::RAD_BITS-1:0]  rs_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         in_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         in_valid_ff <= start & ~busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_shape_ff <= '{req_first_is_rect, req_first_x, req_first_y,
                      req_first_size_a, req_first_size_b};
      q_shape_ff <= '{req_second_is_rect, req_second_x, req_second_y,
                      req_second_size_a, req_second_size_b};
   end

   assign busy = busy_ff;

   // edges of both shapes
   spo_box u_box_p (
      .shape (p_shape_ff),
      .geo   (p_geo_in)
   );

   spo_box u_box_q (
      .shape (q_shape_ff),
      .geo   (q_geo_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_valid_ff <= 1'b0;
      end else begin
         geo_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_geo_ff <= p_geo_in;
      q_geo_ff <= q_geo_in;
   end

   // deltas per pair kind
   always_comb begin
      if (p_geo_ff.is_rect && q_geo_ff.is_rect) begin
         kind = spo_pkg::KIND_RR;
      end else if (!p_geo_ff.is_rect && !q_geo_ff.is_rect) begin
         kind = spo_pkg::KIND_CC;
      end else begin
         kind = spo_pkg::KIND_CR;
      end
   end

   assign circ = p_geo_ff.is_rect ? q_geo_ff : p_geo_ff;
   assign rect = p_geo_ff.is_rect ? p_geo_ff : q_geo_ff;

   always_comb begin
      dx_in     = '0;
      dy_in     = '0;
      rs_in     = '0;
      rr_hit_in = 1'b0;
      unique case (kind)
         spo_pkg::KIND_CC: begin
            dx_in = p_geo_ff.cx - q_geo_ff.cx;
            dy_in = p_geo_ff.cy - q_geo_ff.cy;
            rs_in = spo_pkg::RAD_BITS'(p_geo_ff.rad) + spo_pkg::RAD_BITS'(q_geo_ff.rad);
         end
         spo_pkg::KIND_RR: begin
            rr_hit_in = ($signed(p_geo_ff.l) < $signed(q_geo_ff.r)) &&
                        ($signed(q_geo_ff.l) < $signed(p_geo_ff.r)) &&
                        ($signed(p_geo_ff.t) < $signed(q_geo_ff.b)) &&
                        ($signed(q_geo_ff.t) < $signed(p_geo_ff.b));
         end
         spo_pkg::KIND_CR: begin
            if ($signed(circ.cx) < $signed(rect.l)) begin
               dx_in = circ.cx - rect.l;
            end else if ($signed(circ.cx) > $signed(rect.r)) begin
               dx_in = circ.cx - rect.r;
            end
            if ($signed(circ.cy) < $signed(rect.t)) begin
               dy_in = circ.cy - rect.t;
            end else if ($signed(circ.cy) > $signed(rect.b)) begin
               dy_in = circ.cy - rect.b;
            end
            rs_in = spo_pkg::RAD_BITS'(circ.rad);
         end
         default: begin
            rr_hit_in = 1'b0;
         end
      endcase
   end

   assign ctl_in.valid  = geo_valid_ff;
   assign ctl_in.use_rr = (kind == spo_pkg::KIND_RR);
   assign ctl_in.rr_hit = rr_hit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      rs_ff <= rs_in;
   end

   // squares, compare and result register
   spo_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_ff),
      .dx      (dx_ff),
      .dy      (dy_ff),
      .rs      (rs_ff),
      .strobe  (rsp_strobe),
      .overlap (rsp_overlap)
   );

endmodule

>>> hdl/spo_checker.sv
// port level checks for the shape pair overlap test, with its bind
// depends on spo_pkg and shape_pair_overlap_test
module spo_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_first_is_rect,
   input logic [spo_pkg::COORD_BITS-1:0] req_first_x,
   input logic [spo_pkg::COORD_BITS-1:0] req_first_y,
   input logic [spo_pkg::SIZE_BITS-1:0]  req_first_size_a,
   input logic                           req_second_is_rect,
   input logic [spo_pkg::COORD_BITS-1:0] req_second_x,
   input logic [spo_pkg::COORD_BITS-1:0] req_second_y,
   input logic                           rsp_strobe,
   input logic                           rsp_overlap
);

   logic xfer;

   assign xfer = start && !busy;

   // every transfer gives exactly one result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      xfer |-> ##5 rsp_strobe)
      else $error("result missing after transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(xfer, 5))
      else $error("result without transfer");

   // two concentric circles with nonzero radius always overlap
   a_concentric: assert property (@(posedge clock) disable iff (reset)
      (xfer && !req_first_is_rect && !req_second_is_rect &&
       req_first_x == req_second_x && req_first_y == req_second_y &&
       req_first_size_a != '0) |-> ##5 rsp_overlap)
      else $error("concentric circles reported apart");

   // a zero radius circle never touches a rectangle
   a_point_circle: assert property (@(posedge clock) disable iff (reset)
      (xfer && !req_first_is_rect && req_second_is_rect &&
       req_first_size_a == '0) |-> ##5 !rsp_overlap)
      else $error("zero radius circle reported overlapping");

endmodule

bind shape_pair_overlap_test spo_checker u_spo_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_first_is_rect  (req_first_is_rect),
   .req_first_x        (req_first_x),
   .req_first_y        (req_first_y),
   .req_first_size_a   (req_first_size_a),
   .req_second_is_rect (req_second_is_rect),
   .req_second_x       (req_second_x),
   .req_second_y       (req_second_y),
   .rsp_strobe         (rsp_strobe),
   .rsp_overlap        (rsp_overlap)
);

>>> tb/shape_pair_overlap_checker.sv
// checker for the shape pair overlap test: watches both channels, predicts each overlap bit
// depends on spo_pkg; instantiated by testbench beside the block
`timescale 1ns / 100ps

module shape_pair_overlap_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_first_is_rect,
   input  logic [spo_pkg::COORD_BITS-1:0] req_first_x,
   input  logic [spo_pkg::COORD_BITS-1:0] req_first_y,
   input  logic [spo_pkg::SIZE_BITS-1:0]  req_first_size_a,
   input  logic [spo_pkg::SIZE_BITS-1:0]  req_first_size_b,
   input  logic                           req_second_is_rect,
   input  logic [spo_pkg::COORD_BITS-1:0] req_second_x,
   input  logic [spo_pkg::COORD_BITS-1:0] req_second_y,
   input  logic [spo_pkg::SIZE_BITS-1:0]  req_second_size_a,
   input  logic [spo_pkg::SIZE_BITS-1:0]  req_second_size_b,
   input  logic                           rsp_strobe,
   input  logic                           rsp_overlap,
   output int                             mismatch_count,
   output int                             pending_count
);
   import spo_pkg::*;

   typedef struct {
      int unsigned item;
      logic        overlap;
   } hit_entry_type;

   hit_entry_type hit_queue[$];
   int unsigned   transfer_count;

   function automatic logic circle_meets_rect(input longint cx, input longint cy,
                                              input longint r, input longint rx,
                                              input longint ry, input longint w,
                                              input longint h);
      longint l, t, nx, ny, dx, dy;
      l  = rx - w / 2;
      t  = ry - h / 2;
      nx = (cx < l) ? l : ((cx > l + w) ? l + w : cx);
      ny = (cy < t) ? t : ((cy > t + h) ? t + h : cy);
      dx = cx - nx;
      dy = cy - ny;
      return (dx * dx + dy * dy) < (r * r);
   endfunction

   function automatic logic shapes_overlap(input logic a_rect,
                                           input logic [COORD_BITS-1:0] a_x,
                                           input logic [COORD_BITS-1:0] a_y,
                                           input logic [SIZE_BITS-1:0] a_w,
                                           input logic [SIZE_BITS-1:0] a_h,
                                           input logic b_rect,
                                           input logic [COORD_BITS-1:0] b_x,
                                           input logic [COORD_BITS-1:0] b_y,
                                           input logic [SIZE_BITS-1:0] b_w,
                                           input logic [SIZE_BITS-1:0] b_h);
      longint ax, ay, aw, ah, bx, by, bw, bh, al, at, bl, bt, dx, dy;
      ax = $signed(a_x);
      ay = $signed(a_y);
      bx = $signed(b_x);
      by = $signed(b_y);
      aw = a_w;
      ah = a_h;
      bw = b_w;
      bh = b_h;
      if (!a_rect && !b_rect) begin
         dx = ax - bx;
         dy = ay - by;
         return (dx * dx + dy * dy) < ((aw + bw) * (aw + bw));
      end else if (a_rect && b_rect) begin
         al = ax - aw / 2;
         at = ay - ah / 2;
         bl = bx - bw / 2;
         bt = by - bh / 2;
         return (al < bl + bw) && (bl < al + aw) && (at < bt + bh) && (bt < at + ah);
      end else if (a_rect) begin
         return circle_meets_rect(bx, by, bw, ax, ay, aw, ah);
      end else begin
         return circle_meets_rect(ax, ay, aw, bx, by, bw, bh);
      end
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      transfer_count = 0;
   end

   always @(posedge clock) begin
      hit_entry_type entry;
      if (!reset && start && !busy) begin
         entry.item    = transfer_count;
         entry.overlap = shapes_overlap(req_first_is_rect, req_first_x, req_first_y,
                                        req_first_size_a, req_first_size_b,
                                        req_second_is_rect, req_second_x, req_second_y,
                                        req_second_size_a, req_second_size_b);
         hit_queue.push_back(entry);
         transfer_count++;
      end
      if (!reset && rsp_strobe !== 1'b0) begin
         if (hit_queue.size() == 0) begin
            if (mismatch_count < 10)
               $display("result with no pending transfer: overlap %b", rsp_overlap);
            mismatch_count++;
         end else begin
            entry = hit_queue.pop_front();
            if (rsp_strobe !== 1'b1 || rsp_overlap !== entry.overlap) begin
               if (mismatch_count < 10)
                  $display("transfer %0d: overlap expected %b actual %b (strobe %b)",
                           entry.item, entry.overlap, rsp_overlap, rsp_strobe);
               mismatch_count++;
            end
         end
      end
      pending_count = hit_queue.size();
   end

endmodule

>>> tb/testbench.sv
// top of the shape pair overlap test bench: clock, reset, directed and random shape pairs
// depends on spo_pkg, shape_pair_overlap_test and shape_pair_overlap_checker
`timescale 1ns / 100ps

module testbench;
   import spo_pkg::*;

   localparam int RANDOM_PAIRS = 1700;
   localparam int QUIET_TAIL   = 200;
   localparam int CYCLE_LIMIT  = 100000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_first_is_rect;
   logic [COORD_BITS-1:0] req_first_x;
   logic [COORD_BITS-1:0] req_first_y;
   logic [SIZE_BITS-1:0]  req_first_size_a;
   logic [SIZE_BITS-1:0]  req_first_size_b;
   logic                  req_second_is_rect;
   logic [COORD_BITS-1:0] req_second_x;
   logic [COORD_BITS-1:0] req_second_y;
   logic [SIZE_BITS-1:0]  req_second_size_a;
   logic [SIZE_BITS-1:0]  req_second_size_b;
   logic                  rsp_strobe;
   logic                  rsp_overlap;
   int                    mismatch_count;
   int                    pending_count;
   int                    cycle_count = 0;

   shape_pair_overlap_test i_dut (.*);

   shape_pair_overlap_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("shape_pair_overlap_test verification failed");
         $finish;
      end
   end

   task automatic send_pair(input logic a_rect, input logic [COORD_BITS-1:0] a_x,
                            input logic [COORD_BITS-1:0] a_y,
                            input logic [SIZE_BITS-1:0] a_w, input logic [SIZE_BITS-1:0] a_h,
                            input logic b_rect, input logic [COORD_BITS-1:0] b_x,
                            input logic [COORD_BITS-1:0] b_y,
                            input logic [SIZE_BITS-1:0] b_w, input logic [SIZE_BITS-1:0] b_h);
      start              = 1'b1;
      req_first_is_rect  = a_rect;
      req_first_x        = a_x;
      req_first_y        = a_y;
      req_first_size_a   = a_w;
      req_first_size_b   = a_h;
      req_second_is_rect = b_rect;
      req_second_x       = b_x;
      req_second_y       = b_y;
      req_second_size_a  = b_w;
      req_second_size_b  = b_h;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_off(input int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic [SIZE_BITS-1:0] random_size();
      unique case ($urandom_range(0, 7))
         0: return '0;
         1: return SIZE_BITS'($urandom_range(0, (1 << SIZE_BITS) - 1));
         2: return '1;
         default: return SIZE_BITS'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic send_random_pair();
      logic                  a_rect, b_rect;
      logic [COORD_BITS-1:0] a_x, a_y, b_x, b_y;
      logic [SIZE_BITS-1:0]  a_w, a_h, b_w, b_h;
      int                    span;
      a_rect = 1'($urandom_range(0, 1));
      b_rect = 1'($urandom_range(0, 1));
      a_w    = random_size();
      a_h    = random_size();
      b_w    = random_size();
      b_h    = random_size();
      a_x    = COORD_BITS'($urandom);
      a_y    = COORD_BITS'($urandom);
      if ($urandom_range(0, 4) == 0) begin
         b_x = COORD_BITS'($urandom);
         b_y = COORD_BITS'($urandom);
      end else begin
         // keep the pair close so both outcomes stay common
         span = a_w + a_h + b_w + b_h + 4;
         b_x  = COORD_BITS'(a_x + $urandom_range(0, 2 * span) - span);
         b_y  = COORD_BITS'(a_y + $urandom_range(0, 2 * span) - span);
      end
      send_pair(a_rect, a_x, a_y, a_w, a_h, b_rect, b_x, b_y, b_w, b_h);
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_first_is_rect  = 1'b0;
      req_first_x        = '0;
      req_first_y        = '0;
      req_first_size_a   = '0;
      req_first_size_b   = '0;
      req_second_is_rect = 1'b0;
      req_second_x       = '0;
      req_second_y       = '0;
      req_second_size_a  = '0;
      req_second_size_b  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // circle pairs: zero radius, touching, max sizes at opposite corners
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(0, 0, 0, 5, 0, 0, 10, 0, 5, 0);
      send_pair(0, 0, 0, 5, 0, 0, 9, 0, 5, 0);
      send_pair(0, -32768, -32768, 16383, 16383, 0, 32767, 32767, 16383, 16383);
      send_pair(0, 0, 0, 16383, 0, 0, 32765, 0, 16383, 0);
      // rectangle pairs: shared edge, overlap by one, zero sizes, extremes
      send_pair(1, 0, 0, 4, 4, 1, 4, 0, 4, 4);
      send_pair(1, 0, 0, 4, 4, 1, 3, 0, 4, 4);
      send_pair(1, 0, 0, 0, 4, 1, 0, 0, 4, 4);
      send_pair(1, 7, 7, 0, 0, 1, 7, 7, 0, 0);
      send_pair(1, 32767, 32767, 16383, 16383, 1, -32768, -32768, 16383, 16383);
      send_pair(1, -32768, 32767, 16383, 16383, 1, -32768, 32767, 16383, 16383);
      // circle against rectangle: odd width, both orders, corners, zero radius
      send_pair(1, 0, 0, 5, 5, 0, 5, 0, 2, 0);
      send_pair(0, 5, 0, 3, 9, 1, 0, 0, 5, 5);
      send_pair(0, 0, 0, 1, 0, 1, 0, 0, 100, 100);
      send_pair(1, 0, 0, 100, 100, 0, 0, 0, 0, 0);
      send_pair(1, 0, 0, 10, 10, 0, 8, 8, 4, 0);
      send_pair(0, 8, 8, 5, 16383, 1, 0, 0, 10, 10);
      send_pair(0, -32768, -32768, 16383, 16383, 1, 32767, 32767, 16383, 16383);
      send_pair(1, 32767, -32768, 16383, 16383, 0, 32767, -32768, 16383, 16383);

      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         if (n < RANDOM_PAIRS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 3));
         send_random_pair();
      end
      start = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("shape_pair_overlap_test verification clean");
      end else begin
         $display("shape_pair_overlap_test verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/spo_pkg.sv
hdl/spo_box.sv
hdl/spo_dist.sv
hdl/shape_pair_overlap_test.sv
hdl/spo_checker.sv
tb/shape_pair_overlap_checker.sv
tb/testbench.sv
